// ===== rtl/mpbf_pkg.sv =====
// shared constants, codes and helpers of the byte pipe pool
package mpbf_pkg;

  // pool geometry
  localparam int NUM_PIPES  = 8;
  localparam int RING_DEPTH = 256;
  localparam int PIPE_W     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int STORE_DEPTH = NUM_PIPES * RING_DEPTH;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  // request payload widths
  localparam int CMD_W  = 2;
  localparam int SEL_W  = 3;
  localparam int DATA_W = 8;
  localparam int STAT_W = 3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [PIPE_W-1:0] pipe_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_PIPE = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_EOS     = 3'd4,
    ST_BROKEN  = 3'd5
  } status_t;

  // next ring slot, wrapping at the ring depth
  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t res;
    if (p == ptr_t'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + ptr_t'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/mpbf_if.sv =====
// request and result channel interfaces of the byte pipe pool
interface mpbf_req_if import mpbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SEL_W-1:0]  pipe_sel;
  logic [DATA_W-1:0] write_data;
  logic              close_writer;

  modport source (output valid, cmd, pipe_sel, write_data, close_writer, input ready);
  modport sink   (input valid, cmd, pipe_sel, write_data, close_writer, output ready);
endinterface

interface mpbf_res_if import mpbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] read_data;
  logic [SEL_W-1:0]  new_pipe;

  modport source (output valid, status, read_data, new_pipe, input ready);
  modport sink   (input valid, status, read_data, new_pipe, output ready);
endinterface

// ===== rtl/mpbf_ram.sv =====
// generic single write, single read ram with registered read data
module mpbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/multi_pipe_byte_fifo_pool.sv =====
// top level of the byte pipe pool: pipe bookkeeping, byte store and result pipeline
//
// channel  dir  payload                                  accepted when
// in_ch    in   cmd, pipe_sel, write_data, close_writer  valid && ready
// out_ch   out  status, read_data, new_pipe              valid && ready
//
// one request per cycle while the output is not stalled; each result passes
// the first result stage with the registered store read, then the output register.
// pointers and pipe flags update at the accepting edge, so back-to-back
// requests to the same pipe see each other. synchronous reset frees all pipes;
// the byte store needs no clearing. a stalled output holds the result, one
// more request can enter behind it, then in_ch.ready drops.
module multi_pipe_byte_fifo_pool import mpbf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  mpbf_req_if.sink     in_ch,
  mpbf_res_if.source   out_ch
);

  // per-pipe bookkeeping
  logic in_use_r  [NUM_PIPES];
  logic in_use_nxt[NUM_PIPES];
  ptr_t head_r    [NUM_PIPES];
  ptr_t head_nxt  [NUM_PIPES];
  ptr_t tail_r    [NUM_PIPES];
  ptr_t tail_nxt  [NUM_PIPES];
  logic ropen_r   [NUM_PIPES];
  logic ropen_nxt [NUM_PIPES];
  logic wopen_r   [NUM_PIPES];
  logic wopen_nxt [NUM_PIPES];

  // pipeline stage in front of the output register
  logic              s1_valid_r;
  status_t           s1_status_r;
  status_t           s1_status_nxt;
  logic [SEL_W-1:0]  s1_newp_r;
  logic [SEL_W-1:0]  s1_newp_nxt;
  logic              s1_read_r;
  logic              s1_read_nxt;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [SEL_W-1:0]  out_newp_r;

  logic      accept;
  logic      s1_adv;
  pipe_idx_t sel_idx;
  ptr_t      head_cur;
  ptr_t      tail_cur;
  ptr_t      head_adv;
  logic      is_full;
  logic      is_empty;
  logic      found_ok;
  pipe_idx_t found_idx;
  cmd_t      cmd;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // handshake
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // selected pipe view
  assign cmd      = cmd_t'(in_ch.cmd);
  assign sel_idx  = pipe_idx_t'(32'(in_ch.pipe_sel) % NUM_PIPES);
  assign head_cur = head_r[sel_idx];
  assign tail_cur = tail_r[sel_idx];
  assign head_adv = ring_next(head_cur);
  assign is_full  = (head_adv == tail_cur);
  assign is_empty = (head_cur == tail_cur);

  assign ram_waddr = ADDR_W'(32'(sel_idx) * RING_DEPTH) + ADDR_W'(head_cur);
  assign ram_raddr = ADDR_W'(32'(sel_idx) * RING_DEPTH) + ADDR_W'(tail_cur);

  // lowest free pipe
  always_comb begin
    found_ok  = 1'b0;
    found_idx = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found_ok  = 1'b1;
        found_idx = pipe_idx_t'(i);
      end
    end
  end

  // request decode and bookkeeping update
  always_comb begin
    in_use_nxt    = in_use_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ropen_nxt     = ropen_r;
    wopen_nxt     = wopen_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    s1_status_nxt = ST_OK;
    s1_newp_nxt   = '0;
    s1_read_nxt   = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_CREATE: begin
          if (found_ok) begin
            in_use_nxt[found_idx] = 1'b1;
            head_nxt[found_idx]   = '0;
            tail_nxt[found_idx]   = '0;
            ropen_nxt[found_idx]  = 1'b1;
            wopen_nxt[found_idx]  = 1'b1;
            s1_newp_nxt           = SEL_W'(found_idx);
          end else begin
            s1_status_nxt = ST_NO_PIPE;
          end
        end
        CMD_WRITE: begin
          if (!is_full) begin
            ram_we            = 1'b1;
            head_nxt[sel_idx] = head_adv;
          end else begin
            s1_status_nxt = ropen_r[sel_idx] ? ST_FULL : ST_BROKEN;
          end
        end
        CMD_READ: begin
          if (!is_empty) begin
            ram_re            = 1'b1;
            s1_read_nxt       = 1'b1;
            tail_nxt[sel_idx] = ring_next(tail_cur);
          end else begin
            s1_status_nxt = wopen_r[sel_idx] ? ST_EMPTY : ST_EOS;
          end
        end
        CMD_CLOSE: begin
          if (in_ch.close_writer) begin
            wopen_nxt[sel_idx] = 1'b0;
          end else begin
            ropen_nxt[sel_idx] = 1'b0;
          end
          if (!ropen_nxt[sel_idx] && !wopen_nxt[sel_idx]) begin
            in_use_nxt[sel_idx] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PIPES; i++) begin
        in_use_r[i] <= 1'b0;
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
        ropen_r[i]  <= 1'b0;
        wopen_r[i]  <= 1'b0;
      end
    end else begin
      in_use_r <= in_use_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      ropen_r  <= ropen_nxt;
      wopen_r  <= wopen_nxt;
    end
  end

  // byte store
  mpbf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_ch.write_data),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // first result stage, waits for the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_newp_r   <= s1_newp_nxt;
      s1_read_r   <= s1_read_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_rdata_r  <= s1_read_r ? ram_rdata : '0;
      out_newp_r   <= s1_newp_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.read_data = out_rdata_r;
  assign out_ch.new_pipe  = out_newp_r;

endmodule

// ===== verif/multi_pipe_byte_fifo_pool_tb.sv =====
// self-checking testbench of the byte pipe pool: random and directed requests, in-order result check
module multi_pipe_byte_fifo_pool_tb import mpbf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1500;
  localparam int PHASE_LEN    = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    cmd_t              op;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
    logic              cw;
    bit                hold;  // wait for all results before this request
  } pipe_req_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] rdata;
    logic [SEL_W-1:0]  newp;
  } pipe_res_t;

  logic clk;
  logic rst_n;

  mpbf_req_if in_ch ();
  mpbf_res_if out_ch ();

  multi_pipe_byte_fifo_pool uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // stimulus and expectation stores
  pipe_req_t req_q [$];
  pipe_res_t want_q [$];
  bit        pend_hold = 1'b0;

  int in_cnt       = 0;
  int out_cnt      = 0;
  int busy_cnt     = 0;
  int quiet_cycles = 0;
  int phase        = 0;
  int err_cnt      = 0;
  int status_seen [6] = '{default: 0};

  // predictor state of the pool
  logic              pool_used [NUM_PIPES] = '{default: 1'b0};
  logic              rd_open   [NUM_PIPES] = '{default: 1'b0};
  logic              wr_open   [NUM_PIPES] = '{default: 1'b0};
  ptr_t              wr_ptr    [NUM_PIPES] = '{default: '0};
  ptr_t              rd_ptr    [NUM_PIPES] = '{default: '0};
  logic [DATA_W-1:0] ring_mem  [NUM_PIPES][RING_DEPTH];

  always #5 clk = ~clk;

  function automatic void report_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  // apply one request to the pool state and return its result
  function automatic pipe_res_t pipe_step(input cmd_t op, input logic [SEL_W-1:0] sel_raw,
                                          input logic [DATA_W-1:0] din, input logic cw);
    pipe_res_t r;
    int        p;
    int        found;
    ptr_t      nxt;
    r.status = ST_OK;
    r.rdata  = '0;
    r.newp   = '0;
    p = int'(sel_raw) % NUM_PIPES;
    case (op)
      CMD_CREATE: begin
        // lowest free pipe wins
        found = -1;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
          if (!pool_used[i]) found = i;
        end
        if (found < 0) begin
          r.status = ST_NO_PIPE;
        end else begin
          pool_used[found] = 1'b1;
          rd_open[found]   = 1'b1;
          wr_open[found]   = 1'b1;
          wr_ptr[found]    = '0;
          rd_ptr[found]    = '0;
          r.newp           = SEL_W'(found);
        end
      end
      CMD_WRITE: begin
        nxt = ptr_t'((int'(wr_ptr[p]) + 1) % RING_DEPTH);
        if (nxt != rd_ptr[p]) begin
          ring_mem[p][wr_ptr[p]] = din;
          wr_ptr[p] = nxt;
        end else begin
          r.status = rd_open[p] ? ST_FULL : ST_BROKEN;
        end
      end
      CMD_READ: begin
        if (wr_ptr[p] != rd_ptr[p]) begin
          r.rdata   = ring_mem[p][rd_ptr[p]];
          rd_ptr[p] = ptr_t'((int'(rd_ptr[p]) + 1) % RING_DEPTH);
        end else begin
          r.status = wr_open[p] ? ST_EMPTY : ST_EOS;
        end
      end
      default: begin
        // close one end, free once both are shut
        if (cw) begin
          wr_open[p] = 1'b0;
        end else begin
          rd_open[p] = 1'b0;
        end
        if (!rd_open[p] && !wr_open[p]) pool_used[p] = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic queue_req(input cmd_t op, input int sel, input int data, input bit cw);
    pipe_req_t item;
    item.op   = op;
    item.sel  = SEL_W'(sel);
    item.data = DATA_W'(data);
    item.cw   = cw;
    item.hold = pend_hold;
    pend_hold = 1'b0;
    req_q.push_back(item);
  endtask

  task automatic queue_random_req();
    int   w;
    cmd_t op;
    w = $urandom_range(99);
    if (w < 15) begin
      op = CMD_CREATE;
    end else if (w < 50) begin
      op = CMD_WRITE;
    end else if (w < 85) begin
      op = CMD_READ;
    end else begin
      op = CMD_CLOSE;
    end
    queue_req(op, $urandom_range((1 << SEL_W) - 1), $urandom_range(255), $urandom_range(1));
  endtask

  // driver: presents queued requests, idles per phase
  always @(posedge clk) begin : drv
    pipe_req_t item;
    logic      go;
    int        gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      gap = (phase == 1) ? 62 : (phase == 3) ? 8 : 0;
      go  = 1'b0;
      if (req_q.size() != 0) begin
        go = ($urandom_range(99) >= gap);
        // a held request waits until the pool has answered everything
        if (req_q[0].hold && (in_ch.valid || busy_cnt != 0)) go = 1'b0;
      end
      if (go) begin
        item = req_q.pop_front();
        in_ch.cmd          <= item.op;
        in_ch.pipe_sel     <= item.sel;
        in_ch.write_data   <= item.data;
        in_ch.close_writer <= item.cw;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks results, predicts accepted requests, stalls the result side
  always @(posedge clk) begin : mon
    pipe_res_t want;
    logic      got_in;
    logic      got_out;
    int        stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      got_in  = in_ch.valid && in_ch.ready;
      got_out = out_ch.valid && out_ch.ready;
      // compare result with the oldest outstanding expectation
      if (got_out) begin
        if (want_q.size() == 0) begin
          report_error($sformatf("result %0d with nothing outstanding: status %0d data %02h pipe %0d",
                                 out_cnt, out_ch.status, out_ch.read_data, out_ch.new_pipe));
        end else begin
          want = want_q.pop_front();
          if (out_ch.status !== want.status)
            report_error($sformatf("result %0d status: expected %0d, got %0d",
                                   out_cnt, want.status, out_ch.status));
          if (out_ch.read_data !== want.rdata)
            report_error($sformatf("result %0d read_data: expected %02h, got %02h",
                                   out_cnt, want.rdata, out_ch.read_data));
          if (out_ch.new_pipe !== want.newp)
            report_error($sformatf("result %0d new_pipe: expected %0d, got %0d",
                                   out_cnt, want.newp, out_ch.new_pipe));
        end
      end
      // predict the accepted request
      if (got_in) begin
        want = pipe_step(cmd_t'(in_ch.cmd), in_ch.pipe_sel, in_ch.write_data,
                         in_ch.close_writer);
        status_seen[int'(want.status)]++;
        want_q.push_back(want);
      end
      in_cnt   <= in_cnt + int'(got_in);
      out_cnt  <= out_cnt + int'(got_out);
      busy_cnt <= busy_cnt + int'(got_in) - int'(got_out);
      phase    <= ((in_cnt + int'(got_in)) / PHASE_LEN) % 4;
      // watchdog on cycles with no handshake at all
      if (got_in || got_out) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
      stall = (phase == 2) ? 62 : (phase == 3) ? 8 : 0;
      out_ch.ready <= ($urandom_range(99) >= stall);
    end
  end

  initial begin : stim
    int p;
    int n;
    bit long_done;
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = '0;
    in_ch.pipe_sel     = '0;
    in_ch.write_data   = '0;
    in_ch.close_writer = 1'b0;
    out_ch.ready       = 1'b0;

    // directed: unallocated pipes, pool exhaustion, empty, end of stream, closes
    queue_req(CMD_READ, 0, 8'h00, 1'b0);
    queue_req(CMD_WRITE, 7, 8'hFF, 1'b1);
    queue_req(CMD_READ, 7, 8'h00, 1'b0);
    repeat (NUM_PIPES + 1) queue_req(CMD_CREATE, 7, 8'h00, 1'b0);
    queue_req(CMD_WRITE, 0, 8'h00, 1'b0);
    queue_req(CMD_WRITE, 0, 8'hA5, 1'b0);
    repeat (3) queue_req(CMD_READ, 0, 8'hFF, 1'b0);
    queue_req(CMD_CLOSE, 3, 8'h00, 1'b1);
    queue_req(CMD_READ, 3, 8'h00, 1'b0);
    queue_req(CMD_CLOSE, 3, 8'h00, 1'b1);
    queue_req(CMD_CLOSE, 3, 8'h00, 1'b0);
    queue_req(CMD_CREATE, 0, 8'h00, 1'b0);
    queue_req(CMD_WRITE, 5, 8'h5A, 1'b0);
    queue_req(CMD_CLOSE, 5, 8'h00, 1'b0);
    queue_req(CMD_WRITE, 5, 8'h3C, 1'b0);
    queue_req(CMD_CLOSE, 5, 8'hFF, 1'b0);

    // random part: mixed requests, short write/read bursts, pipe recycling
    pend_hold = 1'b1;
    long_done = 1'b0;
    while (req_q.size() < ITEM_TARGET) begin
      if (!long_done && req_q.size() >= 500) begin
        // fill pipe 0 past full, shut the reader, then drain past empty
        long_done = 1'b1;
        pend_hold = 1'b1;
        queue_req(CMD_CLOSE, 0, $urandom_range(255), 1'b0);
        queue_req(CMD_CLOSE, 0, $urandom_range(255), 1'b1);
        queue_req(CMD_CREATE, $urandom_range(7), $urandom_range(255), $urandom_range(1));
        repeat (RING_DEPTH + 1) queue_req(CMD_WRITE, 0, $urandom_range(255), $urandom_range(1));
        queue_req(CMD_CLOSE, 0, $urandom_range(255), 1'b0);
        repeat (2) queue_req(CMD_WRITE, 0, $urandom_range(255), $urandom_range(1));
        repeat (RING_DEPTH + 1) queue_req(CMD_READ, 0, $urandom_range(255), $urandom_range(1));
        queue_req(CMD_CLOSE, 0, $urandom_range(255), 1'b1);
        queue_req(CMD_READ, 0, $urandom_range(255), $urandom_range(1));
      end
      n = $urandom_range(99);
      p = $urandom_range(NUM_PIPES - 1);
      if (n < 60) begin
        queue_random_req();
      end else if (n < 92) begin
        // burst of writes then reads on one pipe
        repeat ($urandom_range(1, 24)) queue_req(CMD_WRITE, p, $urandom_range(255), 1'b0);
        if ($urandom_range(4) == 0) queue_req(CMD_CLOSE, p, 0, $urandom_range(1));
        repeat ($urandom_range(1, 24)) queue_req(CMD_READ, p, $urandom_range(255), 1'b1);
      end else begin
        // recycle a pipe
        queue_req(CMD_CLOSE, p, $urandom_range(255), 1'b0);
        queue_req(CMD_CLOSE, p, $urandom_range(255), 1'b1);
        queue_req(CMD_CREATE, $urandom_range(7), $urandom_range(255), $urandom_range(1));
      end
    end

    // reset
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all requests to be taken and answered
    do begin
      @(negedge clk);
    end while (req_q.size() != 0 || in_ch.valid || busy_cnt != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
    if (want_q.size() != 0)
      report_error($sformatf("%0d results never arrived", want_q.size()));

    $display("covered %0d requests and %0d results across %0d pipes of depth %0d",
             in_cnt, out_cnt, NUM_PIPES, RING_DEPTH);
    $display("statuses: ok %0d, no pipe %0d, empty %0d, full %0d, end of stream %0d, broken %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
